// ===== design/mwtg_pkg.sv =====
// Package for the tone generator: widths, register indexes, waveform codes and the sine ROM.
package mwtg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 8;
   localparam int QROM_N          = 1 << SINE_TABLE_BITS;
   localparam int QROM_SIZE       = QROM_N + 1;
   localparam int QIDX_BITS       = SINE_TABLE_BITS + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INC = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM  = 2'd2;

   localparam logic [2:0] WAVE_SINE     = 3'd1;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
   localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;
   localparam logic [2:0] WAVE_SQUARE   = 3'd4;

   localparam logic [15:0] AMPLITUDE_RESET = 16'd16384;
   localparam logic [2:0]  WAVEFORM_RESET  = WAVE_SINE;

   // ceil(2^26 / 10): exact quotient for every numerator below 2^20.
   localparam logic [22:0] SAW_RECIP = 23'd6710887;
   localparam int          SAW_SHIFT = 26;

   localparam logic signed [16:0] SQUARE_LEVEL = 17'sd22938;

   typedef logic [16:0] qrom_type [0:QROM_SIZE-1];

   // Quarter-wave sine in Q1.15 from a fixed-point Taylor series, built at elaboration.
   function automatic qrom_type build_qrom();
      qrom_type    rom;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] s;
      for (int k = 0; k < QROM_SIZE; k++) begin
         t  = 64'(k) << (30 - SINE_TABLE_BITS);
         t2 = (t * t) >> 30;
         r  = 64'd172272;
         r  = 64'd5026995 - ((r * t2) >> 30);
         r  = 64'd85569306 - ((r * t2) >> 30);
         r  = 64'd693598668 - ((r * t2) >> 30);
         r  = 64'd1686629713 - ((r * t2) >> 30);
         s  = (((r * t) >> 30) + 64'd16384) >> 15;
         if (s > 64'd32768) begin
            s = 64'd32768;
         end
         rom[k] = 17'(s);
      end
      return rom;
   endfunction

   localparam qrom_type QROM = build_qrom();

endpackage

// ===== design/mwtg_if.sv =====
// Valid/ready channel interfaces for tone generator requests and samples.
interface mwtg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface mwtg_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/mwtg_phase.sv =====
// Phase accumulator and input register: captures the cycle fraction for each request.
module mwtg_phase (
   input  logic        clock,
   input  logic        reset,
   mwtg_req_if.sink    req,
   input  logic [31:0] phase_inc,
   input  logic        down_ready,
   output logic        valid,
   output logic [15:0] frac,
   output logic        silent
);
   import mwtg_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] base;
   logic                  valid_ff, valid_in;
   logic [15:0]           frac_ff;
   logic                  silent_ff;
   logic                  take;

   assign req.ready = !valid_ff || down_ready;
   assign take      = req.valid && req.ready;

   // Restart zeroes the phase before this sample is formed.
   assign base     = req.restart ? '0 : phase_ff;
   assign phase_in = take ? base + PHASE_BITS'(phase_inc) : phase_ff;
   assign valid_in = take ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         frac_ff   <= base[PHASE_BITS-1 -: 16];
         silent_ff <= (phase_inc == 32'd0);
      end
   end

   assign valid  = valid_ff;
   assign frac   = frac_ff;
   assign silent = silent_ff;
endmodule

// ===== design/mwtg_wave.sv =====
// Waveform stage: turns the cycle fraction into a signed Q1.15 level.
module mwtg_wave (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [15:0]        frac,
   input  logic               silent,
   input  logic [2:0]         waveform,
   input  logic               down_ready,
   output logic               valid,
   output logic signed [16:0] level
);
   import mwtg_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [16:0]          level_ff, level_in;
   logic                        take;
   logic [1:0]                  quad;
   logic [SINE_TABLE_BITS-1:0]  idx;
   logic [QIDX_BITS-1:0]        rom_addr;
   logic [16:0]                 rom_val;
   logic signed [17:0]          twice;
   logic [19:0]                 saw_num;
   logic [42:0]                 saw_prod;
   logic [16:0]                 saw_quot;

   assign up_ready = !valid_ff || down_ready;
   assign take     = up_valid && up_ready;

   assign quad     = frac[15:14];
   assign idx      = frac[13 -: SINE_TABLE_BITS];
   // Odd quadrants run the table backwards.
   assign rom_addr = quad[0] ? QIDX_BITS'(QROM_N) - {1'b0, idx} : {1'b0, idx};
   assign rom_val  = QROM[rom_addr];

   assign twice    = $signed({1'b0, frac, 1'b0});

   // Sawtooth: (917509 - 9u) / 10 - 65536, quotient by reciprocal multiply.
   assign saw_num  = 20'd917509 - ({4'd0, frac} << 3) - {4'd0, frac};
   assign saw_prod = 43'(saw_num) * 43'(SAW_RECIP);
   assign saw_quot = saw_prod[SAW_SHIFT +: 17];

   always_comb begin
      level_in = '0;
      if (!silent) begin
         case (waveform)
            WAVE_SINE: begin
               level_in = quad[1] ? -$signed(rom_val) : $signed(rom_val);
            end
            WAVE_TRIANGLE: begin
               if (frac < 16'd16384) begin
                  level_in = 17'(twice);
               end else if (frac < 16'd49152) begin
                  level_in = 17'(18'sd65536 - twice);
               end else begin
                  level_in = 17'(twice - 18'sd131072);
               end
            end
            WAVE_SAWTOOTH: begin
               level_in = 17'($signed({1'b0, saw_quot}) - 18'sd65536);
            end
            WAVE_SQUARE: begin
               level_in = frac[15] ? -SQUARE_LEVEL : SQUARE_LEVEL;
            end
            default: begin
               level_in = '0;
            end
         endcase
      end
   end

   assign valid_in = take ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         level_ff <= level_in;
      end
   end

   assign valid = valid_ff;
   assign level = level_ff;
endmodule

// ===== design/mwtg_gain.sv =====
// Gain stages: amplitude multiply, then scale by 32767, round and saturate into the result register.
module mwtg_gain (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic signed [16:0] level,
   input  logic [15:0]        amplitude,
   mwtg_rsp_if.source         rsp
);
   import mwtg_pkg::*;

   logic                      mul_valid_ff, mul_valid_in;
   logic signed [33:0]        prod_ff;
   logic                      mul_ready;
   logic                      take_mul;
   logic                      out_valid_ff, out_valid_in;
   logic signed [15:0]        sample_ff, sample_in;
   logic                      take_out;
   logic signed [49:0]        scaled;
   logic signed [20:0]        rounded;

   assign mul_ready = !out_valid_ff || rsp.ready;
   assign up_ready  = !mul_valid_ff || mul_ready;
   assign take_mul  = up_valid && up_ready;
   assign take_out  = mul_valid_ff && mul_ready;

   // Times 32767 as a shift and subtract; rounding is half up, then floor.
   assign scaled  = (50'(prod_ff) <<< 15) - 50'(prod_ff) + 50'sd268435456;
   assign rounded = 21'(scaled >>> 29);

   always_comb begin
      if (rounded > 21'sd32767) begin
         sample_in = 16'sd32767;
      end else if (rounded < -21'sd32768) begin
         sample_in = -16'sd32768;
      end else begin
         sample_in = 16'(rounded);
      end
   end

   assign mul_valid_in = take_mul ? 1'b1 : (mul_ready ? 1'b0 : mul_valid_ff);
   assign out_valid_in = take_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_mul) begin
         prod_ff <= level * $signed({1'b0, amplitude});
      end
      if (take_out) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.sample = sample_ff;
endmodule

// ===== design/multi_waveform_tone_generator_unit.sv =====
// Top level of the multi-waveform tone generator: control registers and the sample pipeline.
//
// Each request on req carries one restart bit and yields exactly one signed 16-bit
// sample on rsp, in request order. Restart zeroes the phase before the sample is made;
// the phase then advances by the phase increment after every request.
// The csr port writes the phase increment, the amplitude (unsigned Q2.14) and the
// waveform code (1 sine, 2 triangle, 3 sawtooth, 4 square, others silent); an
// unused index is ignored. Write registers only while no request is in flight.
// A zero phase increment gives silent samples and holds the phase.
// There are four register stages: input register, waveform stage, amplitude multiply,
// then scale, round and saturate into the output register. The sample is valid on rsp
// once the request has passed through all four of these registers in order.
// Throughput is one request per cycle while rsp is not stalled; a stage takes a new item
// while it passes its last one on. When rsp is stalled, the pipeline keeps filling its
// empty stages, so up to four requests are taken before req.ready falls. Reset clears
// the phase and the pipeline and loads increment 0, amplitude 1.0 and sine.
module multi_waveform_tone_generator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   mwtg_req_if.sink                               req,
   mwtg_rsp_if.source                             rsp,
   input  logic                                   csr_we,
   input  logic [mwtg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mwtg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import mwtg_pkg::*;

   logic [31:0]        phase_inc_ff, phase_inc_in;
   logic [15:0]        amplitude_ff, amplitude_in;
   logic [2:0]         waveform_ff, waveform_in;

   logic               s1_valid;
   logic [15:0]        s1_frac;
   logic               s1_silent;
   logic               s2_ready;
   logic               s2_valid;
   logic signed [16:0] s2_level;
   logic               s3_ready;

   always_comb begin
      phase_inc_in = phase_inc_ff;
      amplitude_in = amplitude_ff;
      waveform_in  = waveform_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_INC: phase_inc_in = csr_wdata;
            CSR_AMPLITUDE: amplitude_in = csr_wdata[15:0];
            CSR_WAVEFORM:  waveform_in  = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= '0;
         amplitude_ff <= AMPLITUDE_RESET;
         waveform_ff  <= WAVEFORM_RESET;
      end else begin
         phase_inc_ff <= phase_inc_in;
         amplitude_ff <= amplitude_in;
         waveform_ff  <= waveform_in;
      end
   end

   mwtg_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .phase_inc  (phase_inc_ff),
      .down_ready (s2_ready),
      .valid      (s1_valid),
      .frac       (s1_frac),
      .silent     (s1_silent)
   );

   mwtg_wave u_wave (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (s1_valid),
      .up_ready   (s2_ready),
      .frac       (s1_frac),
      .silent     (s1_silent),
      .waveform   (waveform_ff),
      .down_ready (s3_ready),
      .valid      (s2_valid),
      .level      (s2_level)
   );

   mwtg_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (s2_valid),
      .up_ready  (s3_ready),
      .level     (s2_level),
      .amplitude (amplitude_ff),
      .rsp       (rsp)
   );
endmodule

// ===== tb/mwtg_sample_checker.sv =====
`timescale 1ns / 100ps
// Sample checker for the tone generator: predicts every sample and compares it with the output.
module mwtg_sample_checker (
   input  logic                                clock,
   input  logic                                reset,
   mwtg_req_if                                 req,
   mwtg_rsp_if                                 rsp,
   input  logic                                csr_we,
   input  logic [mwtg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mwtg_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output int                                  compared_count
);
   import mwtg_pkg::*;

   localparam int REPORT_LIMIT = 30;

   logic [16:0]           sine_quarter [0:QROM_SIZE-1];
   logic [PHASE_BITS-1:0] phase_acc;
   logic [31:0]           increment;
   logic [15:0]           gain;
   logic [2:0]            wave_sel;
   logic signed [15:0]    expected_samples [$];

   // Odd-power series of sin(pi/2 * t) in Q30, evaluated by Horner's rule on t squared.
   function automatic logic [16:0] quarter_sine_entry(input int k);
      bit [63:0] coeff [0:4] = '{64'd172272, 64'd5026995, 64'd85569306,
                                 64'd693598668, 64'd1686629713};
      bit [63:0] t;
      bit [63:0] t_sq;
      bit [63:0] acc;
      bit [63:0] level;
      t    = 64'(k) << (30 - SINE_TABLE_BITS);
      t_sq = (t * t) >> 30;
      acc  = coeff[0];
      for (int i = 1; i < 5; i++) begin
         acc = coeff[i] - ((acc * t_sq) >> 30);
      end
      level = (((acc * t) >> 30) + 64'd16384) >> 15;
      if (level > 64'd32768) begin
         level = 64'd32768;
      end
      return 17'(level);
   endfunction

   // Waveform value in Q1.15 for the cycle fraction u (Q0.16).
   function automatic int waveform_level(input logic [15:0] u);
      logic [1:0]                 quadrant;
      logic [SINE_TABLE_BITS-1:0] slot;
      int                         mag;
      int                         uu;
      uu = int'(u);
      case (wave_sel)
         WAVE_SINE: begin
            quadrant = u[15:14];
            slot     = u[13 -: SINE_TABLE_BITS];
            mag      = quadrant[0] ? int'(sine_quarter[QROM_N - int'(slot)])
                                   : int'(sine_quarter[slot]);
            return quadrant[1] ? -mag : mag;
         end
         WAVE_TRIANGLE: begin
            if (uu < 16384) begin
               return 2 * uu;
            end
            if (uu < 49152) begin
               return 65536 - 2 * uu;
            end
            return 2 * uu - 131072;
         end
         WAVE_SAWTOOTH: begin
            // 0.8 - 1.8x rounded half up, offset so the quotient stays positive.
            return (917509 - 9 * uu) / 10 - 65536;
         end
         WAVE_SQUARE: begin
            return (uu < 32768) ? int'(SQUARE_LEVEL) : -int'(SQUARE_LEVEL);
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic logic signed [15:0] scale_sample(input int level);
      longint product;
      longint scaled;
      product = longint'(level) * 32767 * longint'(gain);
      scaled  = (product + (longint'(1) << 28)) >>> 29;
      if (scaled > 32767) begin
         scaled = 32767;
      end
      if (scaled < -32768) begin
         scaled = -32768;
      end
      return 16'(scaled);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      compared_count = 0;
      for (int k = 0; k < QROM_SIZE; k++) begin
         sine_quarter[k] = quarter_sine_entry(k);
      end
   end

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         phase_acc = '0;
         increment = '0;
         gain      = AMPLITUDE_RESET;
         wave_sel  = WAVEFORM_RESET;
         expected_samples.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample %0d arrived with no request outstanding",
                                         rsp.sample));
            end else begin
               want = expected_samples.pop_front();
               if (rsp.sample !== want) begin
                  report_mismatch($sformatf("sample %0d: got %0d, expected %0d",
                                            compared_count, rsp.sample, want));
               end
               compared_count++;
            end
         end
         if (req.valid && req.ready) begin
            if (req.restart) begin
               phase_acc = '0;
            end
            // A zero increment silences the output and freezes the phase.
            if (increment != 0) begin
               want = scale_sample(waveform_level(phase_acc[PHASE_BITS-1 -: 16]));
            end else begin
               want = '0;
            end
            expected_samples.push_back(want);
            phase_acc = phase_acc + PHASE_BITS'(increment);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PHASE_INC: increment = csr_wdata[31:0];
               CSR_AMPLITUDE: gain      = csr_wdata[15:0];
               CSR_WAVEFORM:  wave_sel  = csr_wdata[2:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

// ===== tb/tb_multi_waveform_tone_generator_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the tone generator: clock, reset, stimulus, watchdog and verdict.
module tb_multi_waveform_tone_generator_unit;
   import mwtg_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRESSURE_HOLD   = 250;
   localparam int PIPE_LATENCY    = 4;
   localparam int DRAIN_CYCLES    = 12;
   localparam int RANDOM_PHASES   = 14;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int PRESSURE_PHASE  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED       = 2'd3;
   localparam logic [2:0]                WAVE_SILENT_LOW  = 3'd0;
   localparam logic [2:0]                WAVE_SILENT_HIGH = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int mismatch_count;
   int pending_count;
   int compared_count;
   int idle_cycles = 0;
   int requests_sent = 0;
   int settings_used = 0;
   bit steady = 1'b0;
   bit pressure_request = 1'b0;
   bit pressure_active = 1'b0;
   bit pressure_served = 1'b0;

   mwtg_req_if req_ch ();
   mwtg_rsp_if rsp_ch ();

   multi_waveform_tone_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mwtg_sample_checker sample_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .compared_count (compared_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no request or sample moved for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int draw_gap();
      int roll;
      if (steady || (pressure_request && !pressure_served)) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic restart);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // The first edge lets the checker count the last accepted request.
   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Upper data bits are random so that the registers must ignore them.
   task automatic configure(input logic [31:0] inc, input logic [15:0] amp,
                            input logic [2:0] wave, input bit poke_unused);
      settle_pipeline();
      csr_write(CSR_PHASE_INC, inc);
      csr_write(CSR_AMPLITUDE, {16'($urandom()), amp});
      csr_write(CSR_WAVEFORM, {29'($urandom()), wave});
      if (poke_unused) begin
         csr_write(CSR_UNUSED, $urandom());
      end
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int stall;
      int run;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         // Long hold-off so the pipeline fills and the request side backs up.
         if (pressure_request && !pressure_served) begin
            rsp_ch.ready <= 1'b0;
            pressure_active = 1'b1;
            repeat (PRESSURE_HOLD) @(posedge clock);
            pressure_served = 1'b1;
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         run = $urandom_range(1, 24);
         repeat (run) @(posedge clock);
      end
   end

   initial begin
      logic [31:0] inc;
      logic [15:0] amp;
      logic [2:0]  wave;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_PHASE_INC;
      csr_wdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero increment, so both samples are silent.
      send_request(1'b0);
      send_request(1'b1);

      // Quarter-cycle steps land on every sine quadrant edge, including the full-scale entry.
      configure(32'h4000_0000, 16'd16384, WAVE_SINE, 1'b0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);

      configure(32'h2000_0000, 16'hFFFF, WAVE_TRIANGLE, 1'b0);
      send_request(1'b1);
      repeat (3) send_request(1'b0);

      configure(32'hFFFF_FFFF, 16'd16384, WAVE_SAWTOOTH, 1'b0);
      send_request(1'b1);
      repeat (2) send_request(1'b0);

      configure(32'h0123_4567, 16'd0, WAVE_SQUARE, 1'b0);
      send_request(1'b1);
      send_request(1'b0);

      configure(32'h8000_0000, 16'hFFFF, WAVE_SQUARE, 1'b0);
      send_request(1'b1);
      send_request(1'b0);

      configure(32'h1000_0000, 16'd16384, WAVE_SILENT_LOW, 1'b1);
      send_request(1'b1);
      configure(32'h1000_0000, 16'd16384, WAVE_SILENT_HIGH, 1'b1);
      send_request(1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 7))
            0:       inc = '0;
            1:       inc = 32'hFFFF_FFFF;
            2, 3, 4: inc = $urandom_range(1, 32'h0100_0000);
            default: inc = $urandom();
         endcase
         case ($urandom_range(0, 5))
            0:       amp = '0;
            1:       amp = 16'hFFFF;
            2:       amp = 16'd16384;
            default: amp = 16'($urandom_range(0, 65535));
         endcase
         if (p < 8) begin
            wave = 3'(p);
         end else begin
            wave = 3'($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0) begin
               wave = 3'($urandom());
            end
         end
         if (p == PRESSURE_PHASE && inc == 0) begin
            inc = $urandom();
         end
         configure(inc, amp, wave, $urandom_range(0, 3) == 0);
         steady = (p % 4 == 1);
         if (p == PRESSURE_PHASE) begin
            // Offer requests only once the receiver has started holding off.
            pressure_request = 1'b1;
            wait (pressure_active);
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_request($urandom_range(0, 9) == 0);
         end
         steady = 1'b0;
      end

      settle_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests sent, %0d samples compared over %0d register settings.",
               requests_sent, compared_count, settings_used);
      $display("Summary: all waveform codes, gain and increment extremes, restarts and a %0d%s",
               PRESSURE_HOLD, "-cycle output stall.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
